[src/nfp_pkg.sv]
// Shared types, codes and helper functions for the nearest free PE mapper.
// Used by nfp_ctrl, nfp_datapath and nearest_free_pe_mapper; no dependencies.
package nfp_pkg;

   localparam int PE_MAX_DEF   = 64;
   localparam int MESH_X_DEF   = 8;
   localparam int TASK_MAX_DEF = 64;

   localparam int CRD_W  = 8;
   localparam int DIST_W = 9;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_PLACE   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NOP     = 2'd3
   } nfp_op_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_TOO_FEW = 2'd1,
      STS_NO_FREE = 2'd2
   } nfp_sts_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RECOUNT,
      ST_LOOKUP,
      ST_SCAN,
      ST_COMMIT
   } nfp_state_type;

   typedef struct packed {
      logic load_item;
      logic cfg_write;
      logic recount_step;
      logic read_src;
      logic scan_step;
      logic commit;
   } nfp_cmd_type;

   typedef struct packed {
      logic scan_last;
   } nfp_sts_type;

   typedef struct packed {
      logic [CRD_W-1:0] row;
      logic [CRD_W-1:0] col;
   } nfp_crd_type;

   function automatic nfp_crd_type nfp_coord(input logic [5:0] pe, input int mesh_x);
      nfp_crd_type c;
      int          r;
      int          row;
      row = 0;
      for (r = 1; r < 64; r++) begin
         if (int'(pe) >= r * mesh_x) begin
            row = r;
         end
      end
      c.row = CRD_W'(row);
      c.col = CRD_W'(int'(pe) - row * mesh_x);
      return c;
   endfunction

   function automatic logic [CRD_W-1:0] nfp_absdiff(input logic [CRD_W-1:0] a,
                                                   input logic [CRD_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

[src/nfp_ctrl.sv]
// Controller state machine of the nearest free PE mapper.
// Drives handshakes and datapath commands; depends on nfp_pkg.
module nfp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   output nfp_pkg::nfp_cmd_type cmd,
   input  nfp_pkg::nfp_sts_type sts
);

   nfp_pkg::nfp_state_type state_ff, state_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic                   out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nfp_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      req_tready    = 1'b0;
      csr_ready     = 1'b0;
      unique case (state_ff)
         nfp_pkg::ST_IDLE: begin
            csr_ready  = 1'b1;
            req_tready = !csr_valid;
            if (csr_valid) begin
               cmd.cfg_write = 1'b1;
               state_in      = nfp_pkg::ST_RECOUNT;
            end else if (req_tvalid) begin
               cmd.load_item = 1'b1;
               if (nfp_pkg::nfp_op_type'(req_tuser) == nfp_pkg::OP_PLACE) begin
                  state_in = nfp_pkg::ST_LOOKUP;
               end else begin
                  state_in = nfp_pkg::ST_COMMIT;
               end
            end
         end
         nfp_pkg::ST_RECOUNT: begin
            cmd.recount_step = 1'b1;
            if (sts.scan_last) begin
               state_in = nfp_pkg::ST_IDLE;
            end
         end
         nfp_pkg::ST_LOOKUP: begin
            cmd.read_src = 1'b1;
            state_in     = nfp_pkg::ST_SCAN;
         end
         nfp_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = nfp_pkg::ST_COMMIT;
            end
         end
         nfp_pkg::ST_COMMIT: begin
            if (out_free) begin
               cmd.commit    = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = nfp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nfp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[src/nfp_datapath.sv]
// Datapath of the nearest free PE mapper: busy map, free count, task table,
// nearest-element scan and result register. Depends on nfp_pkg.
module nfp_datapath #(
   parameter int PE_MAX   = nfp_pkg::PE_MAX_DEF,
   parameter int MESH_X   = nfp_pkg::MESH_X_DEF,
   parameter int TASK_MAX = nfp_pkg::TASK_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nfp_pkg::nfp_cmd_type cmd,
   output nfp_pkg::nfp_sts_type sts,
   input  logic [39:0]          req_tdata,
   input  logic [1:0]           req_tuser,
   input  logic [6:0]           csr_data,
   output logic [15:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser
);

   localparam int PE_W    = $clog2(PE_MAX);
   localparam int ACT_W   = $clog2(PE_MAX + 1);
   localparam int TASK_W  = $clog2(TASK_MAX);
   localparam int ACT_RST = (PE_MAX < 64) ? PE_MAX : 64;

   logic [ACT_W-1:0]  act_ff, act_in;
   logic [ACT_W-1:0]  free_ff;
   logic [PE_MAX-1:0] busy_ff;

   nfp_pkg::nfp_op_type op_ff;
   logic [5:0]          task_ff, pred_ff, target_ff;
   logic [6:0]          count_ff;

   logic [5:0] task_pe_mem [TASK_MAX];
   logic [5:0] src_ff;
   logic       src_ok_ff;

   logic [PE_W-1:0]            scan_ff, best_ff;
   logic [nfp_pkg::CRD_W-1:0]  row_ff, col_ff;
   logic                       found_ff;
   logic [nfp_pkg::DIST_W-1:0] best_d_ff;

   logic [1:0] rsp_sts_ff;
   logic [5:0] rsp_pe_ff;
   logic [3:0] rsp_hop_ff;

   logic [5:0]                 src_pe;
   nfp_pkg::nfp_crd_type       src_crd;
   logic [nfp_pkg::DIST_W-1:0] hop_d;
   logic                       take;
   logic [PE_W-1:0]            tgt_idx;
   logic                       tgt_in, tgt_busy;

   nfp_pkg::nfp_sts_code_type c_sts;
   logic [PE_W-1:0]           c_pe;
   logic [3:0]                c_hop;
   logic                      c_occ, c_rel;

   assign src_pe  = src_ok_ff ? src_ff : 6'd0;
   assign src_crd = nfp_pkg::nfp_coord(src_pe, MESH_X);
   assign hop_d   = nfp_pkg::DIST_W'(nfp_pkg::nfp_absdiff(row_ff, src_crd.row)) +
                    nfp_pkg::DIST_W'(nfp_pkg::nfp_absdiff(col_ff, src_crd.col));
   assign take    = !busy_ff[scan_ff] && (!found_ff || hop_d < best_d_ff);

   assign sts.scan_last = (ACT_W'(scan_ff) == act_ff - ACT_W'(1));

   assign tgt_idx  = PE_W'(target_ff);
   assign tgt_in   = (target_ff != 6'd0) && (target_ff < act_ff);
   assign tgt_busy = busy_ff[tgt_idx];

   always_comb begin
      if (csr_data < 7'd2) begin
         act_in = ACT_W'(2);
      end else if (32'(csr_data) > PE_MAX) begin
         act_in = ACT_W'(PE_MAX);
      end else begin
         act_in = ACT_W'(csr_data);
      end
   end

   always_comb begin
      c_sts = nfp_pkg::STS_OK;
      c_pe  = '0;
      c_hop = '0;
      c_occ = 1'b0;
      c_rel = 1'b0;
      unique case (op_ff)
         nfp_pkg::OP_START: begin
            if (free_ff < count_ff) begin
               c_sts = nfp_pkg::STS_TOO_FEW;
            end else if (!tgt_in || tgt_busy) begin
               c_sts = nfp_pkg::STS_NO_FREE;
            end else begin
               c_occ = 1'b1;
               c_pe  = tgt_idx;
            end
         end
         nfp_pkg::OP_PLACE: begin
            if (!found_ff) begin
               c_sts = nfp_pkg::STS_NO_FREE;
            end else begin
               c_occ = 1'b1;
               c_pe  = best_ff;
               c_hop = (best_d_ff > nfp_pkg::DIST_W'(15)) ? 4'd15 : best_d_ff[3:0];
            end
         end
         nfp_pkg::OP_RELEASE: begin
            if (tgt_in && tgt_busy) begin
               c_rel = 1'b1;
               c_pe  = tgt_idx;
            end
         end
         nfp_pkg::OP_NOP: begin
            c_sts = nfp_pkg::STS_OK;
         end
         default: begin
            c_sts = nfp_pkg::STS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= {{(PE_MAX-1){1'b0}}, 1'b1};
         free_ff <= ACT_W'(ACT_RST - 1);
         act_ff  <= ACT_W'(ACT_RST);
      end else if (cmd.cfg_write) begin
         act_ff  <= act_in;
         free_ff <= '0;
      end else if (cmd.recount_step) begin
         free_ff <= free_ff + ACT_W'(!busy_ff[scan_ff]);
      end else if (cmd.commit) begin
         if (c_occ) begin
            busy_ff[c_pe] <= 1'b1;
            if (free_ff != '0) begin
               free_ff <= free_ff - ACT_W'(1);
            end
         end else if (c_rel) begin
            busy_ff[c_pe] <= 1'b0;
            free_ff       <= free_ff + ACT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff     <= nfp_pkg::nfp_op_type'(req_tuser);
         task_ff   <= req_tdata[13:8];
         pred_ff   <= req_tdata[19:14];
         target_ff <= req_tdata[25:20];
         count_ff  <= req_tdata[32:26];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && c_occ && (32'(task_ff) < TASK_MAX)) begin
         task_pe_mem[TASK_W'(task_ff)] <= 6'(c_pe);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_src) begin
         src_ff    <= task_pe_mem[TASK_W'(pred_ff)];
         src_ok_ff <= (32'(pred_ff) < TASK_MAX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.read_src || cmd.cfg_write) begin
         found_ff <= 1'b0;
      end else if (cmd.scan_step && take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_src || cmd.cfg_write) begin
         scan_ff <= PE_W'(1);
         row_ff  <= '0;
         col_ff  <= nfp_pkg::CRD_W'(1);
      end else if (cmd.scan_step || cmd.recount_step) begin
         scan_ff <= scan_ff + PE_W'(1);
         if (col_ff == nfp_pkg::CRD_W'(MESH_X - 1)) begin
            col_ff <= '0;
            row_ff <= row_ff + nfp_pkg::CRD_W'(1);
         end else begin
            col_ff <= col_ff + nfp_pkg::CRD_W'(1);
         end
      end
      if (cmd.scan_step && take) begin
         best_ff   <= scan_ff;
         best_d_ff <= hop_d;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_sts_ff <= c_sts;
         rsp_pe_ff  <= 6'(c_pe);
         rsp_hop_ff <= c_hop;
      end
   end

   assign rsp_tdata = {6'd0, rsp_hop_ff, rsp_pe_ff};
   assign rsp_tuser = rsp_sts_ff;

`ifndef NO_ASSERTIONS
   a_free_below_active: assert property (@(posedge clock) disable iff (reset)
      free_ff < act_ff)
      else $error("free count reached active element count");

   a_pe0_reserved: assert property (@(posedge clock) disable iff (reset)
      busy_ff[0])
      else $error("element 0 marked free");

   a_place_marks_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (op_ff == nfp_pkg::OP_PLACE) && found_ff |=> busy_ff[best_ff])
      else $error("placed element not marked busy");
`endif

endmodule

[src/nearest_free_pe_mapper.sv]
// Nearest free PE mapper: a start, place, release or no-op transaction in, one result out.
// A start, release or no-op transaction goes from acceptance to the commit state, which
// registers its result; the next transaction can be accepted after the commit. A place
// transaction first looks up its predecessor's element in the task table, then scans the
// busy map, visiting one element per cycle, and then commits; it occupies the block until
// the commit. A result still waiting in the output register holds the commit of the next
// one. A csr_data write recounts free elements over active elements 1 to active_pe_count - 1,
// during which no transaction is accepted. A finished result waits in the output register
// while the next transaction is accepted.
// Depends on nfp_pkg, nfp_ctrl and nfp_datapath.
module nearest_free_pe_mapper #(
   parameter int PE_MAX   = nfp_pkg::PE_MAX_DEF,
   parameter int MESH_X   = nfp_pkg::MESH_X_DEF,
   parameter int TASK_MAX = nfp_pkg::TASK_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // app_id[7:0], task_id[13:8], pred_task_id[19:14], target_pe[25:20],
   // task_count[32:26], zero[39:33]
   input  logic [39:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // chosen_pe[5:0], hop_distance[9:6], zero[15:10]
   output logic [15:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   // active_pe_count
   input  logic [6:0]  csr_data
);

   nfp_pkg::nfp_cmd_type cmd;
   nfp_pkg::nfp_sts_type sts;

   nfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   nfp_datapath #(
      .PE_MAX   (PE_MAX),
      .MESH_X   (MESH_X),
      .TASK_MAX (TASK_MAX)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
